>>> hw/rtl/ppt_pkg.sv
package ppt_pkg;

  typedef struct packed {
    logic              kind;
    logic [3:0]        ticker;
    logic              side;
    logic [1:0]        hedge_side;
    logic [30:0]       fill_qty;
    logic [30:0]       fill_price;
    logic signed [31:0] bid;
    logic signed [31:0] ask;
  } in_t;

  typedef struct packed {
    logic signed [63:0] net_position;
    logic signed [63:0] traded_volume;
    logic signed [63:0] realized;
    logic signed [63:0] unrealized;
    logic signed [63:0] total;
    logic [62:0]        long_quantity;
    logic signed [63:0] long_realized;
    logic signed [63:0] long_unrealized;
    logic [62:0]        short_quantity;
    logic signed [63:0] short_realized;
    logic signed [63:0] short_unrealized;
  } out_t;

  // One instrument slot's position record.
  typedef struct packed {
    logic [63:0] pos_net;
    logic [63:0] vol_sum;
    logic [63:0] open_cost_buy;
    logic [63:0] open_cost_sell;
    logic [63:0] long_qty;
    logic [63:0] long_basis;
    logic [63:0] short_qty;
    logic [63:0] short_cost;
    logic [63:0] long_real;
    logic [63:0] short_real;
    logic [63:0] long_unreal;
    logic [63:0] short_unreal;
    logic [63:0] net_unreal;
    logic [63:0] net_real;
    logic [63:0] total;
  } rec_t;

  localparam logic [1:0] HEDGE_LONG  = 2'd1;
  localparam logic [1:0] HEDGE_SHORT = 2'd2;
  localparam int         XLEN        = 64;

endpackage

>>> hw/rtl/ppt_alu.sv
module ppt_alu (
  input  logic        clk,
  input  logic        rst,
  input  logic        go,
  input  logic        is_div,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic [63:0] res,
  output logic        done
);
  import ppt_pkg::*;

  logic        run;
  logic        div_mode;
  logic        neg;
  logic [6:0]  cnt;
  logic [63:0] x;
  logic [63:0] y;
  logic [63:0] acc;
  logic [64:0] rem_sh;
  logic [64:0] rem_diff;

  assign rem_sh   = {acc, x[63]};
  assign rem_diff = rem_sh - {1'b0, y};

  // Multiply is shift-and-add over the low 64 bits; divide is restoring
  // division on magnitudes with the sign applied at the end.
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go && !run) begin
        div_mode <= is_div;
        neg      <= a[63] ^ b[63];
        acc      <= '0;
        cnt      <= '0;
        if (is_div && b == '0) begin
          res  <= '0;
          done <= 1'b1;
        end else if (is_div && b == '1) begin
          res  <= 64'd0 - a;
          done <= 1'b1;
        end else if (is_div) begin
          x   <= a[63] ? 64'd0 - a : a;
          y   <= b[63] ? 64'd0 - b : b;
          run <= 1'b1;
        end else begin
          x   <= a;
          y   <= b;
          run <= 1'b1;
        end
      end else if (run) begin
        if (cnt == 7'(XLEN)) begin
          run  <= 1'b0;
          done <= 1'b1;
          if (div_mode) begin
            res <= neg ? 64'd0 - x : x;
          end else begin
            res <= acc;
          end
        end else begin
          cnt <= cnt + 7'd1;
          if (div_mode) begin
            if (!rem_diff[64]) begin
              acc <= rem_diff[63:0];
              x   <= {x[62:0], 1'b1};
            end else begin
              acc <= rem_sh[63:0];
              x   <= {x[62:0], 1'b0};
            end
          end else begin
            if (x[0]) begin
              acc <= acc + y;
            end
            x <= {1'b0, x[63:1]};
            y <= {y[62:0], 1'b0};
          end
        end
      end
    end
  end

endmodule

>>> hw/rtl/position_pnl_tracker.sv
// Position and PnL tracker with one record per instrument slot.
// An input word is taken on a clock edge where start is high and busy is
// low. A fill word updates net position, volume, per-side open cost, the
// long or short hedge book and realized/unrealized PnL; a quote word marks
// unrealized PnL at the bid/ask mid. Every word yields one result word on
// result, marked by a one-cycle done strobe; the receiver cannot stall, so
// the result is simply presented for that cycle.
// Every multiply and divide runs on one shared 64-bit shift/add unit; each
// operation holds the sequencer, and busy stays high until the result is
// out. A fill needs between 1 and 12 such operations; a quote needs up to 5.
// A quote with a non-positive price needs none and leaves the record as
// it is; a word for a slot beyond the table yields an all-zero result and
// never raises busy. Busy is already low in the cycle where done is high,
// so the next word may be accepted at the edge that ends that cycle.
// Reset clears every slot record to zero at once and leaves the block idle.
module position_pnl_tracker #(
  parameter int NUM_TICKERS = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  ppt_pkg::in_t  item,
  output logic          busy,
  output logic          done,
  output ppt_pkg::out_t result
);
  import ppt_pkg::*;

  localparam int DEPTH = (NUM_TICKERS < 16) ? NUM_TICKERS : 16;
  localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [4:0] {
    S_IDLE, S_WAIT, S_POS,
    S_H_ADD, S_H_CHK, S_H_AVG, S_H_R, S_H_C, S_H_SUB,
    S_N_CHK, S_N_OWN, S_N_AVG, S_N_OPP, S_N_DEL, S_N_REV,
    S_U_CHK, S_U_SET, S_L_CHK, S_L_AVG, S_L_SET,
    S_S_CHK, S_S_AVG, S_S_SET, S_FIN, S_WB
  } state_t;

  rec_t        mem [DEPTH];
  rec_t        w;
  state_t      state;
  state_t      ret;
  logic [IW-1:0] ix;
  logic        is_quote;
  logic        sell;
  logic [1:0]  hs;
  logic [63:0] qty;
  logic [63:0] px;
  logic [63:0] old;
  logic [63:0] avg;
  logic [63:0] cq;
  logic [63:0] delta;

  logic        alu_go;
  logic        alu_div;
  logic [63:0] alu_a;
  logic [63:0] alu_b;
  logic [63:0] alu_res;
  logic        alu_done;

  ppt_alu u_alu (
    .clk    (clk),
    .rst    (rst),
    .go     (alu_go),
    .is_div (alu_div),
    .a      (alu_a),
    .b      (alu_b),
    .res    (alu_res),
    .done   (alu_done)
  );

  function automatic logic [63:0] mag(input logic [63:0] v);
    return v[63] ? 64'd0 - v : v;
  endfunction

  function automatic logic [63:0] smin(input logic [63:0] p, input logic [63:0] q);
    return ($signed(p) < $signed(q)) ? p : q;
  endfunction

  logic        hl;
  logic        opening;
  logic [63:0] hq;
  logic [63:0] hc;
  logic [63:0] hr;
  logic [63:0] own;
  logic [63:0] opp;
  logic [63:0] sq_in;
  logic [63:0] bid_x;
  logic [63:0] ask_x;
  logic [63:0] mid;
  logic        in_range;
  logic [63:0] h_left;
  logic [63:0] nr_new;

  assign hl       = (hs == HEDGE_LONG);
  assign opening  = hl ? !sell : sell;
  assign hq       = hl ? w.long_qty  : w.short_qty;
  assign hc       = hl ? w.long_basis : w.short_cost;
  assign hr       = hl ? w.long_real : w.short_real;
  assign own      = sell ? w.open_cost_sell : w.open_cost_buy;
  assign opp      = sell ? w.open_cost_buy  : w.open_cost_sell;
  assign sq_in    = sell ? 64'd0 - qty : qty;
  assign bid_x    = 64'(item.bid);
  assign ask_x    = 64'(item.ask);
  assign mid      = {1'b0, 63'((bid_x + ask_x) >> 1)};
  assign in_range = (32'(item.ticker) < NUM_TICKERS);
  assign h_left   = hq - qty;
  assign nr_new   = (hs == HEDGE_LONG || hs == HEDGE_SHORT)
                    ? w.long_real + w.short_real : w.net_real + delta;
  assign busy     = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      ret    <= S_IDLE;
      alu_go <= 1'b0;
      done   <= 1'b0;
      for (int i = 0; i < DEPTH; i++) begin
        mem[i] <= '0;
      end
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            ix       <= item.ticker[IW-1:0];
            w        <= mem[item.ticker[IW-1:0]];
            is_quote <= item.kind;
            sell     <= item.side;
            hs       <= item.hedge_side;
            qty      <= {33'd0, item.fill_qty};
            delta    <= '0;
            if (!in_range) begin
              result <= '0;
              done   <= 1'b1;
            end else if (!item.kind) begin
              px    <= {33'd0, item.fill_price};
              state <= S_POS;
            end else if ($signed(item.bid) <= 0 || $signed(item.ask) <= 0) begin
              state <= S_WB;
            end else begin
              px    <= mid;
              state <= S_U_CHK;
            end
          end
        end
        S_WAIT: begin
          alu_go <= 1'b0;
          if (alu_done) begin
            state <= ret;
          end
        end
        S_POS: begin
          old       <= w.pos_net;
          w.pos_net <= w.pos_net + sq_in;
          w.vol_sum <= w.vol_sum + qty;
          if (hs == HEDGE_LONG || hs == HEDGE_SHORT) begin
            if (opening) begin
              alu_go <= 1'b1; alu_div <= 1'b0; alu_a <= px; alu_b <= qty;
              ret <= S_H_ADD; state <= S_WAIT;
            end else begin
              state <= S_H_CHK;
            end
          end else begin
            state <= S_N_CHK;
          end
        end
        S_H_ADD: begin
          if (hl) begin
            w.long_basis <= w.long_basis + alu_res;
            w.long_qty   <= w.long_qty + qty;
          end else begin
            w.short_cost <= w.short_cost + alu_res;
            w.short_qty  <= w.short_qty + qty;
          end
          state <= S_N_CHK;
        end
        S_H_CHK: begin
          cq <= smin(qty, hq);
          if ($signed(hq) > 0 && $signed(smin(qty, hq)) > 0) begin
            alu_go <= 1'b1; alu_div <= 1'b1; alu_a <= hc; alu_b <= hq;
            ret <= S_H_AVG; state <= S_WAIT;
          end else begin
            state <= S_H_SUB;
          end
        end
        S_H_AVG: begin
          avg    <= alu_res;
          alu_go <= 1'b1; alu_div <= 1'b0; alu_b <= cq;
          alu_a  <= hl ? px - alu_res : alu_res - px;
          ret <= S_H_R; state <= S_WAIT;
        end
        S_H_R: begin
          if (hl) begin
            w.long_real <= hr + alu_res;
          end else begin
            w.short_real <= hr + alu_res;
          end
          alu_go <= 1'b1; alu_div <= 1'b0; alu_a <= avg; alu_b <= cq;
          ret <= S_H_C; state <= S_WAIT;
        end
        S_H_C: begin
          if (hl) begin
            w.long_basis <= hc - alu_res;
          end else begin
            w.short_cost <= hc - alu_res;
          end
          state <= S_H_SUB;
        end
        S_H_SUB: begin
          // A close larger than the book empties it.
          if (hl) begin
            w.long_qty <= h_left[63] ? '0 : h_left;
            if (h_left[63]) begin
              w.long_basis <= '0;
            end
          end else begin
            w.short_qty <= h_left[63] ? '0 : h_left;
            if (h_left[63]) begin
              w.short_cost <= '0;
            end
          end
          state <= S_N_CHK;
        end
        S_N_CHK: begin
          alu_go <= 1'b1;
          state  <= S_WAIT;
          if (old == '0 || old[63] == sell) begin
            alu_div <= 1'b0; alu_a <= px; alu_b <= qty; ret <= S_N_OWN;
          end else begin
            alu_div <= 1'b1; alu_a <= opp; alu_b <= mag(old); ret <= S_N_AVG;
          end
        end
        S_N_OWN: begin
          if (sell) begin
            w.open_cost_sell <= own + alu_res;
          end else begin
            w.open_cost_buy <= own + alu_res;
          end
          state <= S_U_CHK;
        end
        S_N_AVG: begin
          avg    <= alu_res;
          alu_go <= 1'b1; alu_div <= 1'b0; alu_a <= alu_res; alu_b <= mag(w.pos_net);
          ret <= S_N_OPP; state <= S_WAIT;
        end
        S_N_OPP: begin
          if (sell) begin
            w.open_cost_buy <= alu_res;
          end else begin
            w.open_cost_sell <= alu_res;
          end
          alu_go <= 1'b1; alu_div <= 1'b0;
          alu_a  <= smin(qty, mag(old)); alu_b <= avg - px;
          ret <= S_N_DEL; state <= S_WAIT;
        end
        S_N_DEL: begin
          delta <= sell ? 64'd0 - alu_res : alu_res;
          // The fill reverses the position: the remainder opens the own side.
          if (w.pos_net != '0 && w.pos_net[63] != old[63]) begin
            alu_go <= 1'b1; alu_div <= 1'b0; alu_a <= px; alu_b <= mag(w.pos_net);
            ret <= S_N_REV; state <= S_WAIT;
          end else begin
            state <= S_U_CHK;
          end
        end
        S_N_REV: begin
          if (sell) begin
            w.open_cost_sell <= alu_res;
            w.open_cost_buy  <= '0;
          end else begin
            w.open_cost_buy  <= alu_res;
            w.open_cost_sell <= '0;
          end
          state <= S_U_CHK;
        end
        S_U_CHK: begin
          if (w.pos_net == '0) begin
            if (!is_quote) begin
              w.open_cost_buy  <= '0;
              w.open_cost_sell <= '0;
              w.net_unreal     <= '0;
            end
            state <= S_L_CHK;
          end else begin
            alu_go <= 1'b1; alu_div <= 1'b0; alu_a <= px; alu_b <= mag(w.pos_net);
            ret <= S_U_SET; state <= S_WAIT;
          end
        end
        S_U_SET: begin
          w.net_unreal <= w.pos_net[63] ? w.open_cost_sell - alu_res
                                        : alu_res - w.open_cost_buy;
          state <= S_L_CHK;
        end
        S_L_CHK: begin
          if ($signed(w.long_qty) <= 0) begin
            w.long_unreal <= '0;
            state <= S_S_CHK;
          end else begin
            alu_go <= 1'b1; alu_div <= 1'b1; alu_a <= w.long_basis; alu_b <= w.long_qty;
            ret <= S_L_AVG; state <= S_WAIT;
          end
        end
        S_L_AVG: begin
          alu_go <= 1'b1; alu_div <= 1'b0; alu_a <= px - alu_res; alu_b <= w.long_qty;
          ret <= S_L_SET; state <= S_WAIT;
        end
        S_L_SET: begin
          w.long_unreal <= alu_res;
          state <= S_S_CHK;
        end
        S_S_CHK: begin
          if ($signed(w.short_qty) <= 0) begin
            w.short_unreal <= '0;
            state <= S_FIN;
          end else begin
            alu_go <= 1'b1; alu_div <= 1'b1; alu_a <= w.short_cost; alu_b <= w.short_qty;
            ret <= S_S_AVG; state <= S_WAIT;
          end
        end
        S_S_AVG: begin
          alu_go <= 1'b1; alu_div <= 1'b0; alu_a <= alu_res - px; alu_b <= w.short_qty;
          ret <= S_S_SET; state <= S_WAIT;
        end
        S_S_SET: begin
          w.short_unreal <= alu_res;
          state <= S_FIN;
        end
        S_FIN: begin
          if (is_quote) begin
            w.total <= w.net_unreal + w.net_real;
          end else begin
            w.net_real <= nr_new;
            w.total    <= w.net_unreal + nr_new;
          end
          state <= S_WB;
        end
        S_WB: begin
          mem[ix] <= w;
          result.net_position     <= w.pos_net;
          result.traded_volume    <= w.vol_sum;
          result.realized         <= w.net_real;
          result.unrealized       <= w.net_unreal;
          result.total            <= w.total;
          result.long_quantity    <= w.long_qty[62:0];
          result.long_realized    <= w.long_real;
          result.long_unrealized  <= w.long_unreal;
          result.short_quantity   <= w.short_qty[62:0];
          result.short_realized   <= w.short_real;
          result.short_unrealized <= w.short_unreal;
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> sim/position_pnl_tracker_chk.sv
module position_pnl_tracker_chk (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic          busy,
  input  ppt_pkg::in_t  item,
  input  logic          done,
  input  ppt_pkg::out_t result,
  output int            fail_count,
  output int            pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import ppt_pkg::*;

  localparam int NSLOT = 16;
  localparam int NFLD  = 11;

  typedef logic [63:0] u64_t;
  typedef u64_t fields_t [NFLD];

  // Predicted state of every slot record.
  rec_t book [NSLOT];
  out_t snapshot_q [$];
  int   mismatches;

  function automatic u64_t sdiv64(u64_t a, u64_t b);
    if (b == 0) return 0;
    if ($signed(b) == -64'sd1) return -a;
    return u64_t'($signed(a) / $signed(b));
  endfunction

  function automatic u64_t mag64(u64_t u);
    return ($signed(u) < 0) ? -u : u;
  endfunction

  function automatic u64_t smin64(u64_t a, u64_t b);
    return ($signed(a) < $signed(b)) ? a : b;
  endfunction

  function automatic u64_t book_unreal(u64_t qty, u64_t cost, u64_t px, bit is_long);
    u64_t avg;
    if ($signed(qty) <= 0) return 0;
    avg = sdiv64(cost, qty);
    return is_long ? (px - avg) * qty : (avg - px) * qty;
  endfunction

  function automatic out_t snap(rec_t r);
    out_t o;
    o.net_position     = r.pos_net;
    o.traded_volume    = r.vol_sum;
    o.realized         = r.net_real;
    o.unrealized       = r.net_unreal;
    o.total            = r.total;
    o.long_quantity    = r.long_qty[62:0];
    o.long_realized    = r.long_real;
    o.long_unrealized  = r.long_unreal;
    o.short_quantity   = r.short_qty[62:0];
    o.short_realized   = r.short_real;
    o.short_unrealized = r.short_unreal;
    return o;
  endfunction

  function automatic rec_t apply_fill(rec_t r, bit sell, logic [1:0] hs, u64_t qty, u64_t px);
    u64_t old, pos, delta, avg, cq, sgn, own, opp;
    old   = r.pos_net;
    delta = 0;
    sgn   = sell ? -64'd1 : 64'd1;
    own   = sell ? r.open_cost_sell : r.open_cost_buy;
    opp   = sell ? r.open_cost_buy : r.open_cost_sell;
    pos   = old + qty * sgn;
    r.pos_net = pos;
    r.vol_sum = r.vol_sum + qty;

    if (hs == HEDGE_LONG) begin
      if (!sell) begin
        r.long_basis = r.long_basis + px * qty;
        r.long_qty   = r.long_qty + qty;
      end else begin
        cq = smin64(qty, r.long_qty);
        if ($signed(r.long_qty) > 0 && $signed(cq) > 0) begin
          avg = sdiv64(r.long_basis, r.long_qty);
          r.long_real  = r.long_real + (px - avg) * cq;
          r.long_basis = r.long_basis - avg * cq;
        end
        r.long_qty = r.long_qty - qty;
        if ($signed(r.long_qty) < 0) begin
          r.long_qty   = 0;
          r.long_basis = 0;
        end
      end
    end else if (hs == HEDGE_SHORT) begin
      if (sell) begin
        r.short_cost = r.short_cost + px * qty;
        r.short_qty  = r.short_qty + qty;
      end else begin
        cq = smin64(qty, r.short_qty);
        if ($signed(r.short_qty) > 0 && $signed(cq) > 0) begin
          avg = sdiv64(r.short_cost, r.short_qty);
          r.short_real = r.short_real + (avg - px) * cq;
          r.short_cost = r.short_cost - avg * cq;
        end
        r.short_qty = r.short_qty - qty;
        if ($signed(r.short_qty) < 0) begin
          r.short_qty  = 0;
          r.short_cost = 0;
        end
      end
    end

    // Adding to the position, or reducing / reversing it.
    if (old == 0 || (($signed(old) < 0) == sell)) begin
      own = own + px * qty;
    end else begin
      avg   = sdiv64(opp, mag64(old));
      opp   = avg * mag64(pos);
      delta = smin64(qty, mag64(old)) * (avg - px) * sgn;
      if (pos != 0 && (($signed(pos) < 0) != ($signed(old) < 0))) begin
        own = px * mag64(pos);
        opp = 0;
      end
    end
    if (sell) begin
      r.open_cost_sell = own;
      r.open_cost_buy  = opp;
    end else begin
      r.open_cost_buy  = own;
      r.open_cost_sell = opp;
    end

    if (pos == 0) begin
      r.open_cost_buy  = 0;
      r.open_cost_sell = 0;
      r.net_unreal     = 0;
    end else if ($signed(pos) > 0) begin
      r.net_unreal = px * mag64(pos) - r.open_cost_buy;
    end else begin
      r.net_unreal = r.open_cost_sell - px * mag64(pos);
    end
    r.long_unreal  = book_unreal(r.long_qty, r.long_basis, px, 1'b1);
    r.short_unreal = book_unreal(r.short_qty, r.short_cost, px, 1'b0);
    if (hs == HEDGE_LONG || hs == HEDGE_SHORT) r.net_real = r.long_real + r.short_real;
    else r.net_real = r.net_real + delta;
    r.total = r.net_unreal + r.net_real;
    return r;
  endfunction

  function automatic rec_t apply_quote(rec_t r, logic signed [31:0] bid,
                                       logic signed [31:0] ask);
    u64_t mid;
    if (bid <= 0 || ask <= 0) return r;
    mid = u64_t'((64'(bid) + 64'(ask)) / 2);
    if (r.pos_net != 0) begin
      if ($signed(r.pos_net) > 0) r.net_unreal = mid * mag64(r.pos_net) - r.open_cost_buy;
      else r.net_unreal = r.open_cost_sell - mid * mag64(r.pos_net);
    end
    r.long_unreal  = book_unreal(r.long_qty, r.long_basis, mid, 1'b1);
    r.short_unreal = book_unreal(r.short_qty, r.short_cost, mid, 1'b0);
    r.total = r.net_unreal + r.net_real;
    return r;
  endfunction

  function automatic fields_t split(out_t o);
    fields_t f;
    f = '{o.net_position, o.traded_volume, o.realized, o.unrealized, o.total,
          {1'b0, o.long_quantity}, o.long_realized, o.long_unrealized,
          {1'b0, o.short_quantity}, o.short_realized, o.short_unrealized};
    return f;
  endfunction

  assign pending = snapshot_q.size();

  always @(posedge clk) begin
    out_t    want;
    fields_t fw, fg;
    int      t;
    int      errs;
    errs = 0;
    if (rst) begin
      foreach (book[i]) book[i] = '0;
      snapshot_q.delete();
      fail_count <= 0;
      mismatches = 0;
    end else begin
      if (done) begin
        if (snapshot_q.size() == 0) begin
          errs++;
          if (mismatches < 10) $display("result word with none expected");
          mismatches++;
        end else begin
          want = snapshot_q.pop_front();
          fw = split(want);
          fg = split(result);
          for (int k = 0; k < NFLD; k++) begin
            if (fw[k] !== fg[k]) begin
              if (mismatches < 10)
                $display("field %0d mismatch: expected %h got %h", k, fw[k], fg[k]);
              mismatches++;
              errs++;
            end
          end
        end
      end
      if (start && !busy) begin
        t = int'(item.ticker);
        if (t >= NSLOT) begin
          snapshot_q.push_back('0);
        end else begin
          if (item.kind == 1'b0)
            book[t] = apply_fill(book[t], item.side, item.hedge_side,
                                 64'(item.fill_qty), 64'(item.fill_price));
          else
            book[t] = apply_quote(book[t], item.bid, item.ask);
          snapshot_q.push_back(snap(book[t]));
        end
      end
      fail_count <= fail_count + errs;
    end
  end

endmodule

>>> sim/position_pnl_tracker_tb.sv
module position_pnl_tracker_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ppt_pkg::*;

  localparam int CYCLE_LIMIT = 8000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  in_t  item = '0;
  logic busy, done;
  out_t result;
  int   fail_count, pending;
  int   cycles = 0;
  int   burst_left = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  position_pnl_tracker u_dut (
    .clk(clk), .rst(rst), .start(start), .item(item),
    .busy(busy), .done(done), .result(result)
  );

  position_pnl_tracker_chk u_chk (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .done(done), .result(result), .fail_count(fail_count), .pending(pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Presents one word and holds it until the block takes it.
  task automatic issue(in_t w);
    item  <= w;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start <= 1'b0;
      burst_left = $urandom_range(0, 15);
      if ($urandom_range(0, 3) != 0) repeat ($urandom_range(1, 300)) @(posedge clk);
    end
  endtask

  function automatic in_t fill_word(int t, bit sell, logic [1:0] hs, int unsigned q,
                                    int unsigned p);
    in_t w;
    w = '0;
    w.ticker = 4'(t);
    w.side = sell;
    w.hedge_side = hs;
    w.fill_qty = 31'(q);
    w.fill_price = 31'(p);
    w.bid = $urandom;
    w.ask = $urandom;
    return w;
  endfunction

  function automatic in_t quote_word(int t, int b, int a);
    in_t w;
    w = '0;
    w.kind = 1'b1;
    w.ticker = 4'(t);
    w.side = 1'($urandom);
    w.hedge_side = 2'($urandom);
    w.fill_qty = 31'($urandom);
    w.fill_price = 31'($urandom);
    w.bid = b;
    w.ask = a;
    return w;
  endfunction

  function automatic int unsigned rand_qty();
    int r;
    r = $urandom_range(0, 99);
    if (r < 2) return 0;
    if (r < 8) return $urandom & 32'h7FFF_FFFF;
    return $urandom_range(1, 1000);
  endfunction

  function automatic int unsigned rand_px();
    if ($urandom_range(0, 19) == 0) return $urandom & 32'h7FFF_FFFF;
    return $urandom_range(1, 100000);
  endfunction

  function automatic in_t rand_word();
    int   t;
    int   b, a;
    t = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 3);
    if ($urandom_range(0, 9) < 3) begin
      if ($urandom_range(0, 7) == 0) begin
        b = $urandom;
        a = $urandom;
      end else begin
        b = $urandom_range(1, 100000);
        a = b + $urandom_range(0, 50);
        if ($urandom_range(0, 20) == 0) a = 32'h7FFF_FFFF;
      end
      return quote_word(t, b, a);
    end
    return fill_word(t, 1'($urandom), 2'($urandom), rand_qty(), rand_px());
  endfunction

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed words: extremes, every hedge side, reversals, bad quotes.
    issue(quote_word(0, 100, 102));
    issue(fill_word(0, 1'b0, 2'd0, 10, 100));
    issue(fill_word(0, 1'b0, 2'd0, 0, 50));
    issue(fill_word(0, 1'b1, 2'd0, 4, 120));
    issue(fill_word(0, 1'b1, 2'd0, 20, 90));
    issue(quote_word(0, 80, 85));
    issue(fill_word(0, 1'b0, 2'd0, 14, 95));
    issue(quote_word(0, 0, 85));
    issue(quote_word(0, 85, -5));
    issue(quote_word(0, 32'h8000_0000, 32'h8000_0000));
    issue(fill_word(1, 1'b0, 2'd1, 30, 200));
    issue(fill_word(1, 1'b1, 2'd1, 10, 250));
    issue(fill_word(1, 1'b1, 2'd1, 50, 180));
    issue(fill_word(1, 1'b1, 2'd2, 40, 300));
    issue(fill_word(1, 1'b0, 2'd2, 15, 280));
    issue(fill_word(1, 1'b0, 2'd2, 60, 310));
    issue(fill_word(1, 1'b0, 2'd3, 7, 77));
    issue(quote_word(1, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    issue(fill_word(2, 1'b0, 2'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    issue(fill_word(2, 1'b0, 2'd1, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    issue(fill_word(2, 1'b1, 2'd0, 32'h7FFF_FFFF, 0));
    issue(fill_word(15, 1'b1, 2'd2, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    issue(quote_word(15, 1, 1));
    issue(quote_word(15, 32'h5555_5555, 32'h2AAA_AAAA));

    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);

    for (int n = 0; n < 1700; n++) issue(rand_word());
    start <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
